// ===== src/abg_pkg.sv =====
// ----------------------------------------------------------------------------
// Anchor box generator package
// Shared types, widths and fixed-point constants of the anchor box generator.
// ----------------------------------------------------------------------------
package abg_pkg;

    localparam int FRAC_BITS = 16;

    localparam int DVD_W  = 29;
    localparam int DVS_W  = 12;
    localparam int QUO_W  = 17;
    localparam int SQV_W  = 36;
    localparam int ROOT_W = 19;

    localparam logic [16:0] ONE_Q      = 17'h10000;
    localparam logic [17:0] BOX_MAX    = 18'h3FFFF;
    localparam logic [15:0] CENTER_MAX = 16'hFFFF;
    localparam logic [17:0] TENTH_Q    = 18'd6554;

    localparam int MODE_FIXED   = 0;
    localparam int MODE_REDUCED = 1;
    localparam int MODE_INTERP  = 2;

    typedef enum logic [2:0] {
        REG_IMAGE_HEIGHT    = 3'd0,
        REG_IMAGE_WIDTH     = 3'd1,
        REG_SCALE_MIN       = 3'd2,
        REG_SCALE_MAX       = 3'd3,
        REG_CENTER_OFFSET_X = 3'd4,
        REG_CENTER_OFFSET_Y = 3'd5,
        REG_STRIDE_CODES    = 3'd6,
        REG_MODE_FLAGS      = 3'd7
    } t_cfg_index;

    typedef struct packed {
        logic [11:0] image_height;
        logic [11:0] image_width;
        logic [15:0] scale_min;
        logic [15:0] scale_max;
        logic [15:0] center_offset_x;
        logic [15:0] center_offset_y;
        logic [31:0] stride_code_list;
        logic [2:0]  mode_flags;
    } t_cfg;

    typedef struct packed {
        logic [15:0] center_x;
        logic [15:0] center_y;
        logic [17:0] box_width;
        logic [17:0] box_height;
        logic [2:0]  layer_index;
        logic        last_anchor;
    } t_result;

    typedef struct packed {
        logic [17:0] h;
        logic [17:0] w;
    } t_size;

endpackage

// ===== src/ssd_anchor_box_generator_core.sv =====
// ----------------------------------------------------------------------------
// SSD anchor box generator
// Produces one anchor box per item, with centres, sizes, layer and last flag.
// ----------------------------------------------------------------------------
// Each item yields one anchor, unless the stride code list is empty. An anchor
// whose cell centres are already held needs no division; the first anchor of
// each cell adds two serial divisions for its centres. Loading a stride group
// adds, per layer, one division for the scale and, with interpolated sizes, a
// further division (none for the last layer) and a serial square root; with
// reduced sizes, layer 0 adds a serial square root instead. A list of a single
// layer needs no division for its scale. Two-beat queues on each side let items
// and results move while the engine works.
module ssd_anchor_box_generator_core #(
    parameter int MAX_LAYERS           = 8,
    parameter int MAX_ANCHORS_PER_CELL = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_restart,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] o_center_x,
    output logic [15:0] o_center_y,
    output logic [17:0] o_box_width,
    output logic [17:0] o_box_height,
    output logic [2:0]  o_layer_index,
    output logic        o_last_anchor,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import abg_pkg::*;

    t_cfg    r_cfg;
    logic    cfg_wr;
    logic    item_empty;
    logic    item_restart;
    logic    item_pop;
    logic    res_full;
    logic    res_push;
    t_result res_in;
    t_result res_out;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_height     <= 12'd192;
            r_cfg.image_width      <= 12'd192;
            r_cfg.scale_min        <= 16'd9728;
            r_cfg.scale_max        <= 16'd49152;
            r_cfg.center_offset_x  <= 16'd32768;
            r_cfg.center_offset_y  <= 16'd32768;
            r_cfg.stride_code_list <= 32'd17475;
            r_cfg.mode_flags       <= 3'd5;
        end else if (cfg_wr) begin
            case (t_cfg_index'(i_cfg_index))
                REG_IMAGE_HEIGHT:    r_cfg.image_height     <= i_cfg_data[11:0];
                REG_IMAGE_WIDTH:     r_cfg.image_width      <= i_cfg_data[11:0];
                REG_SCALE_MIN:       r_cfg.scale_min        <= i_cfg_data[15:0];
                REG_SCALE_MAX:       r_cfg.scale_max        <= i_cfg_data[15:0];
                REG_CENTER_OFFSET_X: r_cfg.center_offset_x  <= i_cfg_data[15:0];
                REG_CENTER_OFFSET_Y: r_cfg.center_offset_y  <= i_cfg_data[15:0];
                REG_STRIDE_CODES:    r_cfg.stride_code_list <= i_cfg_data;
                REG_MODE_FLAGS:      r_cfg.mode_flags       <= i_cfg_data[2:0];
                default: begin
                end
            endcase
        end
    end

    abg_fifo #(.WIDTH(1)) u_item_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (i_restart),
        .o_full  (full),
        .i_pop   (item_pop),
        .o_empty (item_empty),
        .o_data  (item_restart)
    );

    abg_engine #(
        .MAX_LAYERS           (MAX_LAYERS),
        .MAX_ANCHORS_PER_CELL (MAX_ANCHORS_PER_CELL)
    ) u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_cfg_wr       (cfg_wr),
        .i_item_valid   (!item_empty),
        .i_item_restart (item_restart),
        .o_item_pop     (item_pop),
        .i_res_full     (res_full),
        .o_res_push     (res_push),
        .o_res          (res_in)
    );

    abg_fifo #(.WIDTH($bits(t_result))) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (res_out)
    );

    assign o_center_x    = res_out.center_x;
    assign o_center_y    = res_out.center_y;
    assign o_box_width   = res_out.box_width;
    assign o_box_height  = res_out.box_height;
    assign o_layer_index = res_out.layer_index;
    assign o_last_anchor = res_out.last_anchor;
endmodule

// ===== src/abg_fifo.sv =====
// ----------------------------------------------------------------------------
// Two-entry queue
// Registered two-deep queue used on the item side and on the result side.
// ----------------------------------------------------------------------------
module abg_fifo #(
    parameter int WIDTH = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end
endmodule

// ===== src/abg_div.sv =====
// ----------------------------------------------------------------------------
// Serial divider
// Restoring divider, one quotient bit a cycle, for quotients below 2^17.
// ----------------------------------------------------------------------------
module abg_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [abg_pkg::DVD_W-1:0] i_dividend,
    input  logic [abg_pkg::DVS_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [abg_pkg::QUO_W-1:0] o_quotient
);
    import abg_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic [4:0]       r_cnt;
    logic [DVS_W-1:0] r_rem;
    logic [QUO_W-1:0] r_lo;
    logic [QUO_W-1:0] r_quo;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             ge;

    assign trial      = {r_rem, r_lo[QUO_W-1]};
    assign diff       = trial - {1'b0, r_dvs};
    assign ge         = (trial >= {1'b0, r_dvs});
    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(QUO_W);
                r_rem  <= i_dividend[DVD_W-1:QUO_W];
                r_lo   <= i_dividend[QUO_W-1:0];
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
                r_lo  <= {r_lo[QUO_W-2:0], 1'b0};
                r_quo <= {r_quo[QUO_W-2:0], ge};
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
endmodule

// ===== src/abg_isqrt.sv =====
// ----------------------------------------------------------------------------
// Serial square root
// Digit-by-digit square root, one root bit a cycle, rounded to nearest.
// ----------------------------------------------------------------------------
module abg_isqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [abg_pkg::SQV_W-1:0]  i_value,
    output logic                       o_done,
    output logic [abg_pkg::ROOT_W-1:0] o_root
);
    import abg_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic [4:0]       r_cnt;
    logic [SQV_W-1:0] r_val;
    logic [19:0]      r_rem;
    logic [17:0]      r_root;
    logic [21:0]      trial;
    logic [21:0]      test;
    logic             ge;

    assign trial  = {r_rem, r_val[SQV_W-1:SQV_W-2]};
    assign test   = {2'b00, r_root, 2'b01};
    assign ge     = (trial >= test);
    assign o_done = r_done;
    assign o_root = {1'b0, r_root} + ROOT_W'(r_rem > {2'b00, r_root});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd18;
                r_val  <= i_value;
                r_rem  <= 20'd0;
                r_root <= 18'd0;
            end else if (r_busy) begin
                r_rem  <= ge ? 20'(trial - test) : trial[19:0];
                r_root <= {r_root[16:0], ge};
                r_val  <= {r_val[SQV_W-3:0], 2'b00};
                r_cnt  <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
endmodule

// ===== src/abg_engine.sv =====
// ----------------------------------------------------------------------------
// Anchor engine
// Loads the size table of a stride group and walks cells and anchors.
// ----------------------------------------------------------------------------
module abg_engine #(
    parameter int MAX_LAYERS           = 8,
    parameter int MAX_ANCHORS_PER_CELL = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  abg_pkg::t_cfg    i_cfg,
    input  logic             i_cfg_wr,
    input  logic             i_item_valid,
    input  logic             i_item_restart,
    output logic             o_item_pop,
    input  logic             i_res_full,
    output logic             o_res_push,
    output abg_pkg::t_result o_res
);
    import abg_pkg::*;

    localparam int AW = $clog2(MAX_ANCHORS_PER_CELL);
    localparam int CW = $clog2(MAX_ANCHORS_PER_CELL + 1);

    typedef enum logic [15:0] {
        S_IDLE    = 16'h0001,
        S_LOAD    = 16'h0002,
        S_LAYER   = 16'h0004,
        S_SDIV    = 16'h0008,
        S_SCALED  = 16'h0010,
        S_NXDIV   = 16'h0020,
        S_MUL     = 16'h0040,
        S_SQ_GO   = 16'h0080,
        S_SQ_WAIT = 16'h0100,
        S_RPUT0   = 16'h0200,
        S_RPUT1   = 16'h0400,
        S_RPUT2   = 16'h0800,
        S_ANCH    = 16'h1000,
        S_CX      = 16'h2000,
        S_CY      = 16'h4000,
        S_EMIT    = 16'h8000
    } t_state;

    function automatic logic [3:0] code_of(logic [31:0] list, logic [2:0] l);
        return list[{l, 2'b00} +: 4];
    endfunction

    function automatic logic [11:0] grid_dim(logic [11:0] p, logic [3:0] code);
        logic [15:0] pp;
        logic [15:0] m;
        pp = {4'b0, (p == 12'd0) ? 12'd1 : p};
        m  = (16'd1 << code) - 16'd1;
        return 12'((pp + m) >> code);
    endfunction

    function automatic logic [DVD_W-1:0] scale_num(logic [15:0] smin, logic [15:0] smax,
                                                   logic [2:0] den, logic [2:0] l);
        logic [18:0] a;
        logic [18:0] b;
        a = 19'(smin) * 19'(den - l);
        b = 19'(smax) * 19'(l);
        return DVD_W'(a + b + 19'(den >> 1));
    endfunction

    function automatic logic [17:0] sat18(logic [ROOT_W-1:0] v);
        return (v > ROOT_W'(BOX_MAX)) ? BOX_MAX : v[17:0];
    endfunction

    function automatic logic [15:0] sat16(logic [QUO_W-1:0] v);
        return (v > QUO_W'(CENTER_MAX)) ? CENTER_MAX : v[15:0];
    endfunction

    t_state            r_state, n_state;
    logic [2:0]        r_gfl, n_gfl;
    logic [3:0]        r_gel, n_gel;
    logic [11:0]       r_col, n_col;
    logic [11:0]       r_row, n_row;
    logic [CW-1:0]     r_aic, n_aic;
    logic [CW-1:0]     r_apc, n_apc;
    logic [11:0]       r_gw, n_gw;
    logic [11:0]       r_gh, n_gh;
    logic [3:0]        r_code, n_code;
    logic [3:0]        r_layer, n_layer;
    logic [15:0]       r_scale, n_scale;
    logic [16:0]       r_nx, n_nx;
    logic [SQV_W-1:0]  r_prod, n_prod;
    logic              r_red, n_red;
    logic [ROOT_W-1:0] r_t2, n_t2;
    logic [15:0]       r_cx, n_cx;
    logic [15:0]       r_cy, n_cy;
    logic              r_ctr_ok, n_ctr_ok;
    t_size             r_size [MAX_ANCHORS_PER_CELL];

    logic [3:0]        n_layers;
    logic              cnt_stop;
    logic [2:0]        den;
    logic [2:0]        eff_gfl;
    logic [3:0]        eff_gel;
    logic              put_en;
    logic [ROOT_W-1:0] put_w;
    logic [ROOT_W-1:0] put_h;
    logic              div_start;
    logic [DVD_W-1:0]  div_dvd;
    logic [DVS_W-1:0]  div_dvs;
    logic              div_done;
    logic [QUO_W-1:0]  div_quo;
    logic              sq_start;
    logic              sq_done;
    logic [ROOT_W-1:0] sq_root;
    logic [19:0]       t2p1;
    logic [19:0]       t2p2;
    logic [ROOT_W-1:0] big;
    logic [ROOT_W-1:0] small_sz;
    logic [DVD_W-1:0]  cx_num;
    logic [DVD_W-1:0]  cy_num;
    logic [CW-1:0]     aic_inc;
    logic              last;
    t_size             entry;

    always_comb begin
        n_layers = 4'd0;
        cnt_stop = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (!cnt_stop && i < MAX_LAYERS && i_cfg.stride_code_list[4*i +: 4] != 4'd0) begin
                n_layers = 4'(i + 1);
            end else begin
                cnt_stop = 1'b1;
            end
        end
    end

    assign den      = 3'(n_layers - 4'd1);
    assign eff_gfl  = i_item_restart ? 3'd0 : r_gfl;
    assign eff_gel  = i_item_restart ? 4'd0 : r_gel;
    assign t2p1     = {1'b0, r_t2} + 20'd1;
    assign t2p2     = {1'b0, r_t2} + 20'd2;
    assign big      = t2p1[19:1];
    assign small_sz = {1'b0, t2p2[19:2]};
    assign cx_num   = (DVD_W'(r_col) << FRAC_BITS) + DVD_W'(i_cfg.center_offset_x)
                      + DVD_W'(r_gw >> 1);
    assign cy_num   = (DVD_W'(r_row) << FRAC_BITS) + DVD_W'(i_cfg.center_offset_y)
                      + DVD_W'(r_gh >> 1);
    assign aic_inc  = r_aic + CW'(1);
    assign entry    = r_size[r_aic[AW-1:0]];
    assign last     = (r_gel == n_layers) && ({1'b0, r_row} + 13'd1 == {1'b0, r_gh})
                      && ({1'b0, r_col} + 13'd1 == {1'b0, r_gw}) && (aic_inc == r_apc);

    always_comb begin
        o_res.center_x    = r_cx;
        o_res.center_y    = r_cy;
        o_res.box_width   = i_cfg.mode_flags[MODE_FIXED] ? 18'(ONE_Q) : entry.w;
        o_res.box_height  = i_cfg.mode_flags[MODE_FIXED] ? 18'(ONE_Q) : entry.h;
        o_res.layer_index = r_gfl;
        o_res.last_anchor = last;
    end

    always_comb begin
        n_state   = r_state;
        n_gfl     = r_gfl;
        n_gel     = r_gel;
        n_col     = r_col;
        n_row     = r_row;
        n_aic     = r_aic;
        n_apc     = r_apc;
        n_gw      = r_gw;
        n_gh      = r_gh;
        n_code    = r_code;
        n_layer   = r_layer;
        n_scale   = r_scale;
        n_nx      = r_nx;
        n_prod    = r_prod;
        n_red     = r_red;
        n_t2      = r_t2;
        n_cx      = r_cx;
        n_cy      = r_cy;
        n_ctr_ok  = i_cfg_wr ? 1'b0 : r_ctr_ok;
        o_item_pop = 1'b0;
        o_res_push = 1'b0;
        put_en    = 1'b0;
        put_w     = '0;
        put_h     = '0;
        div_start = 1'b0;
        div_dvd   = '0;
        div_dvs   = '0;
        sq_start  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_item_valid && !i_res_full) begin
                    o_item_pop = 1'b1;
                    n_gfl = eff_gfl;
                    n_gel = eff_gel;
                    if (n_layers == 4'd0) begin
                        n_state = S_IDLE;
                    end else if (eff_gel == 4'd0 || eff_gel > n_layers || r_apc == '0) begin
                        if ({1'b0, eff_gfl} >= n_layers) begin
                            n_gfl = 3'd0;
                        end
                        n_state = S_LOAD;
                    end else begin
                        n_state = S_ANCH;
                    end
                end
            end
            S_LOAD: begin
                n_code  = code_of(i_cfg.stride_code_list, r_gfl);
                n_layer = {1'b0, r_gfl};
                n_apc   = '0;
                n_gw    = grid_dim(i_cfg.image_width, code_of(i_cfg.stride_code_list, r_gfl));
                n_gh    = grid_dim(i_cfg.image_height, code_of(i_cfg.stride_code_list, r_gfl));
                n_state = S_LAYER;
            end
            S_LAYER: begin
                if (r_layer < n_layers &&
                    code_of(i_cfg.stride_code_list, r_layer[2:0]) == r_code) begin
                    if (n_layers < 4'd2) begin
                        n_scale = i_cfg.scale_min;
                        n_state = S_SCALED;
                    end else begin
                        div_start = 1'b1;
                        div_dvd   = scale_num(i_cfg.scale_min, i_cfg.scale_max, den,
                                              r_layer[2:0]);
                        div_dvs   = DVS_W'(den);
                        n_state   = S_SDIV;
                    end
                end else begin
                    n_gel    = r_layer;
                    n_col    = '0;
                    n_row    = '0;
                    n_aic    = '0;
                    n_ctr_ok = 1'b0;
                    n_state  = S_ANCH;
                end
            end
            S_SDIV: begin
                if (div_done) begin
                    n_scale = div_quo[15:0];
                    n_state = S_SCALED;
                end
            end
            S_SCALED: begin
                if (r_layer == 4'd0 && i_cfg.mode_flags[MODE_REDUCED]) begin
                    n_prod  = SQV_W'({32'(r_scale) * 32'(r_scale), 3'b000});
                    n_red   = 1'b1;
                    n_state = S_SQ_GO;
                end else begin
                    n_red  = 1'b0;
                    put_en = 1'b1;
                    put_w  = ROOT_W'(r_scale);
                    put_h  = ROOT_W'(r_scale);
                    if (i_cfg.mode_flags[MODE_INTERP]) begin
                        if (r_layer + 4'd1 == n_layers) begin
                            n_nx    = ONE_Q;
                            n_state = S_MUL;
                        end else begin
                            div_start = 1'b1;
                            div_dvd   = scale_num(i_cfg.scale_min, i_cfg.scale_max, den,
                                                  3'(r_layer + 4'd1));
                            div_dvs   = DVS_W'(den);
                            n_state   = S_NXDIV;
                        end
                    end else begin
                        n_layer = r_layer + 4'd1;
                        n_state = S_LAYER;
                    end
                end
            end
            S_NXDIV: begin
                if (div_done) begin
                    n_nx    = div_quo;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = SQV_W'(33'(r_scale) * 33'(r_nx));
                n_state = S_SQ_GO;
            end
            S_SQ_GO: begin
                sq_start = 1'b1;
                n_state  = S_SQ_WAIT;
            end
            S_SQ_WAIT: begin
                if (sq_done) begin
                    if (r_red) begin
                        n_t2    = sq_root;
                        n_state = S_RPUT0;
                    end else begin
                        put_en  = 1'b1;
                        put_w   = sq_root;
                        put_h   = sq_root;
                        n_layer = r_layer + 4'd1;
                        n_state = S_LAYER;
                    end
                end
            end
            S_RPUT0: begin
                put_en  = 1'b1;
                put_w   = ROOT_W'(TENTH_Q);
                put_h   = ROOT_W'(TENTH_Q);
                n_state = S_RPUT1;
            end
            S_RPUT1: begin
                put_en  = 1'b1;
                put_w   = big;
                put_h   = small_sz;
                n_state = S_RPUT2;
            end
            S_RPUT2: begin
                put_en  = 1'b1;
                put_w   = small_sz;
                put_h   = big;
                n_layer = r_layer + 4'd1;
                n_state = S_LAYER;
            end
            S_ANCH: begin
                if (r_aic >= r_apc) begin
                    n_aic = '0;
                end
                if (r_ctr_ok) begin
                    n_state = S_EMIT;
                end else begin
                    div_start = 1'b1;
                    div_dvd   = cx_num;
                    div_dvs   = r_gw;
                    n_state   = S_CX;
                end
            end
            S_CX: begin
                if (div_done) begin
                    n_cx      = sat16(div_quo);
                    div_start = 1'b1;
                    div_dvd   = cy_num;
                    div_dvs   = r_gh;
                    n_state   = S_CY;
                end
            end
            S_CY: begin
                if (div_done) begin
                    n_cy     = sat16(div_quo);
                    n_ctr_ok = 1'b1;
                    n_state  = S_EMIT;
                end
            end
            S_EMIT: begin
                o_res_push = 1'b1;
                n_aic      = aic_inc;
                if (aic_inc >= r_apc) begin
                    n_aic    = '0;
                    n_ctr_ok = 1'b0;
                    n_col    = r_col + 12'd1;
                    if ({1'b0, r_col} + 13'd1 >= {1'b0, r_gw}) begin
                        n_col = '0;
                        n_row = r_row + 12'd1;
                        if ({1'b0, r_row} + 13'd1 >= {1'b0, r_gh}) begin
                            n_row = '0;
                            n_gfl = (r_gel >= n_layers) ? 3'd0 : r_gel[2:0];
                            n_gel = 4'd0;
                        end
                    end
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (put_en && r_apc < CW'(MAX_ANCHORS_PER_CELL)) begin
            n_apc = r_apc + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_gfl    <= '0;
            r_gel    <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_aic    <= '0;
            r_apc    <= '0;
            r_gw     <= '0;
            r_gh     <= '0;
            r_ctr_ok <= 1'b0;
            r_red    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_gfl    <= n_gfl;
            r_gel    <= n_gel;
            r_col    <= n_col;
            r_row    <= n_row;
            r_aic    <= n_aic;
            r_apc    <= n_apc;
            r_gw     <= n_gw;
            r_gh     <= n_gh;
            r_ctr_ok <= n_ctr_ok;
            r_red    <= n_red;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code  <= n_code;
        r_layer <= n_layer;
        r_scale <= n_scale;
        r_nx    <= n_nx;
        r_prod  <= n_prod;
        r_t2    <= n_t2;
        r_cx    <= n_cx;
        r_cy    <= n_cy;
        if (put_en && r_apc < CW'(MAX_ANCHORS_PER_CELL)) begin
            r_size[r_apc[AW-1:0]] <= '{h: sat18(put_h), w: sat18(put_w)};
        end
    end

    abg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    abg_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_value (r_prod),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );
endmodule
